@@ rtl/rps_pkg.sv @@
// Package with shared constants and types for the shuffle unit.
`default_nettype none
package rps_pkg;
  localparam int MaxEntries = 256;
  localparam int IdxW = 8;
  localparam int WordW = 31;
  localparam int SizeW = 9;

  // One queued work item handed from front to back.
  typedef struct packed {
    logic [WordW-1:0] word;
    logic [IdxW-1:0]  pos;
    logic             first;
  } job_t;

  // Back end state machine.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_MOD   = 2'd1,
    ST_READ  = 2'd2,
    ST_WRITE = 2'd3
  } bstate_t;
endpackage
`default_nettype wire

@@ rtl/rps_ram.sv @@
// Generic single-write RAM with one registered read port.
`default_nettype none
module rps_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/rps_front.sv @@
// Front end: accepts words, tracks the position countdown and queues jobs.
`default_nettype none
module rps_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [rps_pkg::SizeW-1:0]  cfg_wr_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [rps_pkg::WordW-1:0]  in_word,
  output logic                            q_valid,
  input  wire logic                       q_ready,
  output rps_pkg::job_t                   q_job
);
  import rps_pkg::*;

  logic [SizeW-1:0] size_r;
  logic [IdxW-1:0]  pos_r, pos_nxt, start_pos;
  logic             pend_r, pend_nxt;
  logic             full_r, full_nxt;
  job_t             job_r, job_nxt;
  logic             acc;

  // Clamp the configured size to 1..MaxEntries and take size minus one.
  always_comb begin
    if (size_r == '0) start_pos = '0;
    else if (size_r > SizeW'(MaxEntries)) start_pos = IdxW'(MaxEntries - 1);
    else start_pos = IdxW'(size_r - 1'b1);
  end

  assign in_ready = !full_r || q_ready;
  assign acc = in_valid && in_ready;
  assign q_valid = full_r;
  assign q_job = job_r;

  // Next position, round flag and one-entry queue.
  always_comb begin
    pos_nxt = pos_r;
    pend_nxt = pend_r;
    full_nxt = full_r && !q_ready;
    job_nxt = job_r;
    if (acc) begin
      job_nxt.word = in_word;
      job_nxt.pos = pend_r ? start_pos : pos_r;
      job_nxt.first = pend_r;
      full_nxt = 1'b1;
      pend_nxt = (job_nxt.pos == '0);
      pos_nxt = job_nxt.pos - 1'b1;
    end
    if (cfg_wr_en) pend_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SizeW'(MaxEntries);
      pend_r <= 1'b1;
      full_r <= 1'b0;
      pos_r <= '0;
    end else begin
      if (cfg_wr_en) size_r <= cfg_wr_data;
      pend_r <= pend_nxt;
      full_r <= full_nxt;
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) job_r <= job_nxt;
endmodule
`default_nettype wire

@@ rtl/rps_back.sv @@
// Back end: reduces the word modulo i+1, swaps entries and emits the result.
`default_nettype none
module rps_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_valid,
  output logic                            q_ready,
  input  rps_pkg::job_t                   q_job,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [rps_pkg::IdxW-1:0]        out_pos,
  output logic [rps_pkg::IdxW-1:0]        out_val,
  output logic                            out_last
);
  import rps_pkg::*;

  localparam int CntW = $clog2(WordW + 1);

  bstate_t          st_r, st_nxt;
  logic [WordW-1:0] quo_r, quo_nxt;
  logic [IdxW:0]    rem_r, rem_nxt, div_r;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [IdxW-1:0]  i_r, j_r;
  logic             nv_r;
  logic [MaxEntries-1:0] mark_r;
  logic [IdxW-1:0]  vi_r, vj_r;
  logic             ovalid_r;
  logic [IdxW-1:0]  opos_r, oval_r;
  logic             olast_r;
  logic [IdxW:0]    trial;
  logic [IdxW-1:0]  ram_raddr, ram_waddr, ram_wdata, ram_rdata;
  logic             ram_we;
  logic [IdxW-1:0]  vi, vj;
  logic             rd_j;

  assign out_valid = ovalid_r;
  assign out_pos = opos_r;
  assign out_val = oval_r;
  assign out_last = olast_r;

  // Restoring division remainder step, one quotient bit per cycle.
  assign trial = {rem_r[IdxW-1:0], quo_r[WordW-1]};

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (q_valid) st_nxt = ST_MOD;
      ST_MOD:   if (cnt_r == CntW'(WordW - 1)) st_nxt = ST_READ;
      ST_READ:  if (!rd_j) st_nxt = ST_WRITE;
      ST_WRITE: if (!ovalid_r || out_ready) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // Datapath control outputs.
  always_comb begin
    q_ready = (st_r == ST_IDLE);
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    case (st_r)
      ST_IDLE: begin
        quo_nxt = q_job.word;
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      ST_MOD: begin
        quo_nxt = {quo_r[WordW-2:0], 1'b0};
        rem_nxt = (trial >= div_r) ? trial - div_r : trial;
        cnt_nxt = cnt_r + 1'b1;
      end
      default: ;
    endcase
  end

  // Unwritten entries read as their own index.
  assign vi = mark_r[i_r] ? vi_r : i_r;
  assign vj = mark_r[j_r] ? ram_rdata : j_r;
  assign rd_j = (st_r == ST_READ) && !nv_r;

  // Store port use: read i during division, read j, then write back.
  // The value of j is held in vj_r, since its mark is set before the write of i.
  always_comb begin
    ram_raddr = i_r;
    if (st_r == ST_READ) ram_raddr = rem_r[IdxW-1:0];
    ram_we = 1'b0;
    ram_waddr = i_r;
    ram_wdata = vj_r;
    if (st_r == ST_WRITE && (!ovalid_r || out_ready)) ram_we = 1'b1;
  end

  rps_ram #(.Width(IdxW), .Depth(MaxEntries)) u_store (
    .clk   (clk),
    .we    (ram_we || (st_r == ST_READ && nv_r)),
    .waddr ((st_r == ST_READ) ? j_r : ram_waddr),
    .wdata ((st_r == ST_READ) ? vi : ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (st_r == ST_IDLE && q_valid) begin
      i_r <= q_job.pos;
      div_r <= {1'b0, q_job.pos} + 1'b1;
    end
    if (st_r == ST_MOD) vi_r <= ram_rdata;
    if (st_r == ST_READ) begin
      if (!nv_r) j_r <= rem_r[IdxW-1:0];
      else vj_r <= vj;
    end
    if (ram_we) begin
      opos_r <= i_r;
      oval_r <= vj_r;
      olast_r <= (i_r == '0);
    end
  end

  // Control registers: state, marks, output valid, read-phase toggle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      mark_r <= '0;
      ovalid_r <= 1'b0;
      nv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_IDLE && q_valid && q_job.first) mark_r <= '0;
      if (st_r == ST_READ) nv_r <= !nv_r;
      if (st_r == ST_READ && nv_r) mark_r[j_r] <= 1'b1;
      if (ram_we) mark_r[i_r] <= 1'b1;
      if (ram_we) ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ rtl/random_permutation_shuffle_unit.sv @@
// Top level of the Fisher-Yates shuffle unit.
// Each word's result passes the queue hand-off, a bit-serial modulo, two store
// reads and a write-back before it is valid.
// The bit-serial modulo sets the pace; a new job waits for the last write-back.
// A one-entry queue lets the front accept the next word while the back works.
// Reset (rst_n, synchronous, low) sets the size to 256 and starts a new round.
`default_nettype none
module random_permutation_shuffle_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [8:0]  cfg_wr_data,   // perm_size
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,      // [30:0] random_word
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,     // [7:0] position, [15:8] perm_value
  output logic             out_tlast
);
  import rps_pkg::*;

  logic q_valid, q_ready;
  job_t q_job;
  logic [IdxW-1:0] opos, oval;

  rps_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_word(in_tdata[WordW-1:0]),
    .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job)
  );

  rps_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_pos(opos), .out_val(oval), .out_last(out_tlast)
  );

  assign out_tdata = {oval, opos};

  // A result marked last always names position zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[7:0] == 8'd0)
    else $error("last result not at position zero");

  // A waiting result holds its data.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // The back end is ready for the queue only while it is idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    q_ready |-> u_back.st_r == ST_IDLE)
    else $error("queue drained outside idle");
endmodule
`default_nettype wire
